@@ rtl/core/axis_angle_to_rotation_matrix_top_defines.svh @@
// Assertion macros for the axis-angle to rotation matrix block.
// Used by the top level only; no other dependencies.
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_TOP_DEFINES_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define AAR_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define AAR_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

@@ rtl/core/aar_pkg.sv @@
// Shared constants and helpers for the axis-angle to rotation matrix block.
// No dependencies.
package aar_pkg;

	localparam int unsigned ATAN_ENTRIES = 24;
	localparam int unsigned CORDIC_FRAC  = 30;
	localparam int unsigned CW           = 34;   // CORDIC x/y width (|v| < 2^32)
	localparam int unsigned ZW           = 32;   // CORDIC angle width, 2^-21 degree
	localparam logic signed [CW-1:0] CORDIC_INV_GAIN = 34'sd652032874;
	localparam logic signed [19:0] HALF_FULL_TURN    = 20'sd184320;
	localparam logic signed [19:0] HALF_HALF_TURN    = 20'sd92160;
	localparam logic signed [19:0] HALF_QUARTER_TURN = 20'sd46080;

	// Arctangent table in units of 2^-21 degree
	function automatic logic signed [ZW-1:0] atan_deg21(input int unsigned i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 32'sd94371840;
			1: r = 32'sd55710950;
			2: r = 32'sd29436136;
			3: r = 32'sd14942242;
			4: r = 32'sd7500117;
			5: r = 32'sd3753715;
			6: r = 32'sd1877315;
			7: r = 32'sd938715;
			8: r = 32'sd469365;
			9: r = 32'sd234683;
			10: r = 32'sd117342;
			11: r = 32'sd58671;
			12: r = 32'sd29335;
			13: r = 32'sd14668;
			14: r = 32'sd7334;
			15: r = 32'sd3667;
			16: r = 32'sd1833;
			17: r = 32'sd917;
			18: r = 32'sd458;
			19: r = 32'sd229;
			20: r = 32'sd115;
			21: r = 32'sd57;
			22: r = 32'sd29;
			23: r = 32'sd14;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/aar_reduce.sv @@
// Angle reduction: half-angle modulo 360 degrees, folded into [-90, 90].
// Depends on aar_pkg. Two register stages; modulo by reciprocal multiply.
module aar_reduce (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic signed [23:0]        angle,
	output logic                      out_valid,
	output logic signed [aar_pkg::ZW-1:0] z0,
	output logic                      neg
);
	// 2^40/184320 rounded down; quotient estimate may be one low
	localparam logic [31:0] RECIP = 32'd5965232;

	logic [23:0] mag;
	logic        sgn_s1, v_s1;
	logic [23:0] mag_s1;
	logic [8:0]  q_s1;
	logic [54:0] prod;
	logic [19:0] rem;
	logic signed [20:0] r;
	logic signed [20:0] rf;
	logic        nf;

	// Stage 1: magnitude and quotient estimate
	assign mag  = angle[23] ? 24'(-angle) : 24'(angle);
	assign prod = 55'(mag) * 55'(RECIP);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		sgn_s1 <= angle[23];
		mag_s1 <= mag;
		q_s1   <= prod[48:40];
	end

	// Stage 2: remainder correction, sign restore, fold
	always_comb begin
		logic [31:0] t;
		t   = 32'(mag_s1) - 32'(q_s1) * 32'd184320;
		if (t >= 32'd184320) t = t - 32'd184320;
		rem = t[19:0];
		r   = sgn_s1 ? -21'(rem) : 21'(rem);
		if (r < 0) r = r + 21'(aar_pkg::HALF_FULL_TURN);
		if (r >= 21'(aar_pkg::HALF_HALF_TURN)) r = r - 21'(aar_pkg::HALF_FULL_TURN);
		nf = 1'b0;
		rf = r;
		if (r > 21'(aar_pkg::HALF_QUARTER_TURN)) begin
			rf = r - 21'(aar_pkg::HALF_HALF_TURN);
			nf = 1'b1;
		end else if (r < -21'(aar_pkg::HALF_QUARTER_TURN)) begin
			rf = r + 21'(aar_pkg::HALF_HALF_TURN);
			nf = 1'b1;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s1;
		end
	end
	// Folded angle fits 17 signed bits, so the scaled value fits ZW bits
	always_ff @(posedge clk) begin
		z0  <= {rf[aar_pkg::ZW-13:0], 12'd0};
		neg <= nf;
	end
endmodule

@@ rtl/core/aar_cordic.sv @@
// Pipelined rotation-mode CORDIC, one register stage per iteration.
// Depends on aar_pkg. Carries sideband data alongside.
module aar_cordic #(
	parameter int unsigned STEPS = 16,
	parameter int unsigned SBW   = 49
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [aar_pkg::ZW-1:0] z_in,
	input  logic [SBW-1:0]                sb_in,
	output logic                          out_valid,
	output logic signed [aar_pkg::CW-1:0] cos_o,
	output logic signed [aar_pkg::CW-1:0] sin_o,
	output logic [SBW-1:0]                sb_o
);
	logic                          v_q  [STEPS+1];
	logic signed [aar_pkg::CW-1:0] x_q  [STEPS+1];
	logic signed [aar_pkg::CW-1:0] y_q  [STEPS+1];
	logic signed [aar_pkg::ZW-1:0] z_q  [STEPS+1];
	logic [SBW-1:0]                sb_q [STEPS+1];

	assign v_q[0]  = in_valid;
	assign x_q[0]  = aar_pkg::CORDIC_INV_GAIN;
	assign y_q[0]  = '0;
	assign z_q[0]  = z_in;
	assign sb_q[0] = sb_in;

	// One micro-rotation per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_it
		logic signed [aar_pkg::CW-1:0] xs, ys;
		assign xs = x_q[i] >>> i;
		assign ys = y_q[i] >>> i;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else begin
				v_q[i+1] <= v_q[i];
			end
		end
		always_ff @(posedge clk) begin
			sb_q[i+1] <= sb_q[i];
			if (z_q[i] >= 0) begin
				x_q[i+1] <= x_q[i] - ys;
				y_q[i+1] <= y_q[i] + xs;
				z_q[i+1] <= z_q[i] - aar_pkg::atan_deg21(i);
			end else begin
				x_q[i+1] <= x_q[i] + ys;
				y_q[i+1] <= y_q[i] - xs;
				z_q[i+1] <= z_q[i] + aar_pkg::atan_deg21(i);
			end
		end
	end

	assign out_valid = v_q[STEPS];
	assign cos_o     = x_q[STEPS];
	assign sin_o     = y_q[STEPS];
	assign sb_o      = sb_q[STEPS];
endmodule

@@ rtl/core/aar_matrix.sv @@
// Quaternion scaling and matrix assembly, four register stages.
// Depends on aar_pkg.
module aar_matrix #(
	parameter int unsigned FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [aar_pkg::CW-1:0] cos_i,
	input  logic signed [aar_pkg::CW-1:0] sin_i,
	input  logic                          neg,
	input  logic signed [15:0]            ax,
	input  logic signed [15:0]            ay,
	input  logic signed [15:0]            az,
	output logic                          out_valid,
	output logic signed [15:0]            m [9]
);
	localparam int unsigned SH  = aar_pkg::CORDIC_FRAC - FRAC_BITS;
	localparam int unsigned QW  = FRAC_BITS + 3;          // s, c
	localparam int unsigned VW  = QW;                     // quaternion comps, |v| < 2^(F+2)
	localparam int unsigned PW  = 2 * QW + 1;             // products
	localparam int unsigned SW  = PW + 2;                 // sums
	localparam int unsigned OS  = 2 * FRAC_BITS - 14;

	logic signed [QW-1:0] s_c, c_c;
	logic signed [aar_pkg::CW-1:0] cr, sr;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [QW-1:0] s_s1, c_s1, c_s2;
	logic signed [15:0]   ax_s1, ay_s1, az_s1;
	logic signed [QW+16-1:0] px_s2, py_s2, pz_s2;
	logic signed [VW-1:0] x, y, z;
	logic signed [PW-1:0] xx_s3, xy_s3, xz_s3, yy_s3, yz_s3, zz_s3, wx_s3, wy_s3, wz_s3;
	logic signed [SW-1:0] e [9];
	logic signed [SW-1:0] one;

	// Stage 1: round sine and cosine, apply fold sign
	always_comb begin
		cr  = (cos_i + (aar_pkg::CW'(1) <<< (SH - 1))) >>> SH;
		sr  = (sin_i + (aar_pkg::CW'(1) <<< (SH - 1))) >>> SH;
		c_c = neg ? -QW'(cr) : QW'(cr);
		s_c = neg ? -QW'(sr) : QW'(sr);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		s_s1 <= s_c; c_s1 <= c_c;
		ax_s1 <= ax; ay_s1 <= ay; az_s1 <= az;
	end

	// Stage 2: axis times sine
	always_ff @(posedge clk) begin
		px_s2 <= (QW+16)'(ax_s1) * (QW+16)'(s_s1);
		py_s2 <= (QW+16)'(ay_s1) * (QW+16)'(s_s1);
		pz_s2 <= (QW+16)'(az_s1) * (QW+16)'(s_s1);
		c_s2  <= c_s1;
	end

	// Stage 3: round quaternion vector, form the nine products
	assign x = VW'((px_s2 + (QW+16)'(8192)) >>> 14);
	assign y = VW'((py_s2 + (QW+16)'(8192)) >>> 14);
	assign z = VW'((pz_s2 + (QW+16)'(8192)) >>> 14);
	always_ff @(posedge clk) begin
		xx_s3 <= PW'(x) * PW'(2 * PW'(x));
		xy_s3 <= PW'(x) * PW'(2 * PW'(y));
		xz_s3 <= PW'(x) * PW'(2 * PW'(z));
		yy_s3 <= PW'(y) * PW'(2 * PW'(y));
		yz_s3 <= PW'(y) * PW'(2 * PW'(z));
		zz_s3 <= PW'(z) * PW'(2 * PW'(z));
		wx_s3 <= PW'(c_s2) * PW'(2 * PW'(x));
		wy_s3 <= PW'(c_s2) * PW'(2 * PW'(y));
		wz_s3 <= PW'(c_s2) * PW'(2 * PW'(z));
	end

	// Stage 4: sums, rounding, saturation
	assign one  = SW'(1) <<< (2 * FRAC_BITS);
	assign e[0] = one - (SW'(yy_s3) + SW'(zz_s3));
	assign e[1] = SW'(xy_s3) - SW'(wz_s3);
	assign e[2] = SW'(xz_s3) + SW'(wy_s3);
	assign e[3] = SW'(xy_s3) + SW'(wz_s3);
	assign e[4] = one - (SW'(xx_s3) + SW'(zz_s3));
	assign e[5] = SW'(yz_s3) - SW'(wx_s3);
	assign e[6] = SW'(xz_s3) - SW'(wy_s3);
	assign e[7] = SW'(yz_s3) + SW'(wx_s3);
	assign e[8] = one - (SW'(xx_s3) + SW'(yy_s3));

	for (genvar k = 0; k < 9; k++) begin : g_out
		logic signed [SW-1:0] rr;
		assign rr = (e[k] + (SW'(1) <<< (OS - 1))) >>> OS;
		always_ff @(posedge clk) begin
			if (rr > SW'(32767))       m[k] <= 16'sd32767;
			else if (rr < -SW'(32768)) m[k] <= -16'sd32768;
			else                       m[k] <= rr[15:0];
		end
	end
	assign out_valid = v_s4;
endmodule

@@ rtl/core/axis_angle_to_rotation_matrix_top.sv @@
// Axis-angle to 3x3 rotation matrix, top level.
// Depends on aar_pkg, aar_reduce, aar_cordic, aar_matrix and the defines header.
//
// Fully pipelined: busy is always low, so one transaction is accepted on any
// cycle with start high. Each result appears for one cycle with done high,
// after passing the two reduction stages, the CORDIC stage chain and the four
// matrix stages. The receiver cannot stall.
`include "axis_angle_to_rotation_matrix_top_defines.svh"
module axis_angle_to_rotation_matrix_top #(
	parameter int unsigned CORDIC_STEPS = 16,
	parameter int unsigned FRAC_BITS    = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic signed [23:0] angle_deg,
	output logic               done,
	output logic signed [15:0] m00, m01, m02,
	output logic signed [15:0] m10, m11, m12,
	output logic signed [15:0] m20, m21, m22
);
	localparam int unsigned SBW = 49;
	logic go, rv, cv;
	logic [47:0] ax_s1, ax_s2;
	logic signed [aar_pkg::ZW-1:0] z0;
	logic neg;
	logic signed [aar_pkg::CW-1:0] co, si;
	logic [SBW-1:0] sb;
	logic signed [15:0] m [9];

	assign busy = 1'b0;
	assign go   = start & ~busy;

	aar_reduce u_red (.clk, .arst_n, .in_valid(go), .angle(angle_deg),
		.out_valid(rv), .z0, .neg);

	// Axis delayed to match the reduction stages
	always_ff @(posedge clk) begin
		ax_s1 <= {axis_x, axis_y, axis_z};
		ax_s2 <= ax_s1;
	end

	aar_cordic #(.STEPS(CORDIC_STEPS), .SBW(SBW)) u_cor (.clk, .arst_n,
		.in_valid(rv), .z_in(z0), .sb_in({neg, ax_s2}),
		.out_valid(cv), .cos_o(co), .sin_o(si), .sb_o(sb));

	aar_matrix #(.FRAC_BITS(FRAC_BITS)) u_mat (.clk, .arst_n, .in_valid(cv),
		.cos_i(co), .sin_i(si), .neg(sb[48]),
		.ax(sb[47:32]), .ay(sb[31:16]), .az(sb[15:0]),
		.out_valid(done), .m(m));

	assign m00 = m[0]; assign m01 = m[1]; assign m02 = m[2];
	assign m10 = m[3]; assign m11 = m[4]; assign m12 = m[5];
	assign m20 = m[6]; assign m21 = m[7]; assign m22 = m[8];

	`AAR_ASSERT_NEXT(a_red_valid, clk, arst_n, go, u_red.v_s1)
	`AAR_ASSERT_IMP(a_never_busy, clk, arst_n, 1'b1, !busy)
	`AAR_ASSERT_NEXT(a_cordic_to_mat, clk, arst_n, cv, u_mat.v_s1)
endmodule
